// File: rtl/sha256_stream_hasher_top_assert.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_assert.svh
// Assertion macros used by the hasher top.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  // Opcodes carried on the input tuser
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Padding and block positions
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] BLK_LAST = 6'h3F;
  localparam logic [5:0] RND_LAST = 6'd63;
  localparam logic [2:0] EMIT_LAST = 3'd7;
  localparam logic [1:0] WORD_LAST_BYTE = 2'd3;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADDH,
    ST_EMIT
  } shs_state_t;

  // Source of the byte pushed into the block
  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_PAD
  } shs_bsel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      push;
    shs_bsel_t bsel;
    logic      count_byte;
    logic      latch_len;
    logic      round_en;
    logic      add_hash;
    logic      emit_shift;
  } shs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic blk_end;
    logic pad_len;
    logic rnd_last;
    logic emit_last;
  } shs_stat_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/shs_ctrl.sv
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: absorb, padding, compression rounds, hash update, digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_opcode,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire shs_pkg::shs_stat_t status,
  output shs_pkg::shs_cmd_t      cmd
);
  import shs_pkg::*;

  shs_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;     // finish in progress
  logic       last_r, last_nxt;   // block in flight carries the length

  // Hold state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      last_r  <= last_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    last_nxt   = last_r;
    cmd        = '0;
    cmd.bsel   = BSEL_DATA;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.push = 1'b1;
          if (in_opcode == OP_ABSORB) begin
            cmd.bsel       = BSEL_DATA;
            cmd.count_byte = 1'b1;
            if (status.blk_end) begin
              state_nxt = ST_ROUND;
            end
          end else begin
            // Append the marker byte and capture the bit length
            cmd.bsel      = BSEL_MARK;
            cmd.latch_len = 1'b1;
            fin_nxt       = 1'b1;
            last_nxt      = 1'b0;
            state_nxt     = status.blk_end ? ST_ROUND : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        cmd.bsel = BSEL_PAD;
        if (status.blk_end) begin
          last_nxt  = status.pad_len;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (status.rnd_last) begin
          state_nxt = ST_ADDH;
        end
      end
      ST_ADDH: begin
        cmd.add_hash = 1'b1;
        priority if (fin_r && last_r) begin
          state_nxt = ST_EMIT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.emit_shift = 1'b1;
          if (status.emit_last) begin
            fin_nxt   = 1'b0;
            last_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/shs_datapath.sv
// ----------------------------------------------------------------------------
// shs_datapath
// Byte packing, rolling message schedule, round unit, hash and length state.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire shs_pkg::shs_cmd_t cmd,
  input  wire logic [7:0]        in_byte,
  output shs_pkg::shs_stat_t     status,
  output logic [31:0]            digest_word
);
  import shs_pkg::*;

  logic [5:0]  pos_r, pos_nxt;          // byte position in block
  logic [60:0] cnt_r, cnt_nxt;          // message bytes absorbed
  logic        len_phase_r, len_phase_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  emit_r, emit_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];

  logic [23:0] acc_r;                   // first three bytes of a word
  logic [63:0] len_r;                   // bit length, sent MSB byte first
  logic [31:0] w_r [16];                // schedule window, w_r[0] is current
  logic [31:0] v_r [8];                 // working variables a..h

  logic [7:0]  push_byte;
  logic        pad_len;
  logic        w_shift;
  logic [31:0] w_in;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign pad_len = len_phase_r || (pos_r == LEN_POS);

  // Select the byte entering the block
  always_comb begin
    unique case (cmd.bsel)
      BSEL_DATA: push_byte = in_byte;
      BSEL_MARK: push_byte = PAD_MARK;
      BSEL_PAD:  push_byte = pad_len ? len_r[63:56] : PAD_ZERO;
      default:   push_byte = PAD_ZERO;
    endcase
  end

  // Schedule expansion and round arithmetic
  assign w_new = sml_sig1(w_r[14]) + w_r[9] + sml_sig0(w_r[1]) + w_r[0];
  assign t1 = v_r[7] + big_sig1(v_r[4]) + (v_r[6] ^ (v_r[4] & (v_r[5] ^ v_r[6])))
            + ROUND_K[rnd_r] + w_r[0];
  assign t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) | (v_r[2] & (v_r[0] | v_r[1])));

  assign w_shift = cmd.round_en || (cmd.push && (pos_r[1:0] == WORD_LAST_BYTE));
  assign w_in    = cmd.round_en ? w_new : {acc_r, push_byte};

  // Control counters and hash state
  always_comb begin
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    len_phase_nxt = len_phase_r;
    rnd_nxt       = rnd_r;
    emit_nxt      = emit_r;
    for (int i = 0; i < 8; i++) begin
      hash_nxt[i] = hash_r[i];
    end
    if (cmd.push) begin
      pos_nxt = pos_r + 6'd1;
      if (cmd.bsel == BSEL_PAD && pad_len) begin
        len_phase_nxt = 1'b1;
      end
      if (pos_r == BLK_LAST) begin
        len_phase_nxt = 1'b0;
        rnd_nxt       = '0;
      end
    end
    if (cmd.count_byte) begin
      cnt_nxt = cnt_r + 61'd1;
    end
    if (cmd.latch_len) begin
      cnt_nxt = '0;
    end
    if (cmd.round_en) begin
      rnd_nxt = rnd_r + 6'd1;
    end
    if (cmd.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + v_r[i];
      end
    end
    // Shift the digest out and refill with the initial values
    if (cmd.emit_shift) begin
      for (int i = 0; i < 7; i++) begin
        hash_nxt[i] = hash_r[i + 1];
      end
      hash_nxt[7] = HASH_INIT[emit_r];
      emit_nxt    = emit_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      len_phase_r <= 1'b0;
      rnd_r       <= '0;
      emit_r      <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= HASH_INIT[i];
      end
    end else begin
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      len_phase_r <= len_phase_nxt;
      rnd_r       <= rnd_nxt;
      emit_r      <= emit_nxt;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_nxt[i];
      end
    end
  end

  // Payload registers: packing, length, schedule window, working variables
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc_r <= {acc_r[15:0], push_byte};
    end
    if (cmd.latch_len) begin
      len_r <= {cnt_r, 3'b000};
    end else if (cmd.push && cmd.bsel == BSEL_PAD && pad_len) begin
      len_r <= {len_r[55:0], 8'h00};
    end
    if (w_shift) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_in;
    end
    if (cmd.push && pos_r == BLK_LAST) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= hash_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign status.blk_end   = (pos_r == BLK_LAST);
  assign status.pad_len   = pad_len;
  assign status.rnd_last  = (rnd_r == RND_LAST);
  assign status.emit_last = (emit_r == EMIT_LAST);
  assign digest_word      = hash_r[0];

endmodule

`default_nettype wire

// File: rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream: absorb bytes, finish to emit the 8-word digest.
//
//   Channel | Dir | tdata             | tuser       | tlast
//   in_     | in  | [7:0] data_byte   | [0] opcode  | -
//   out_    | out | [31:0] digest_word| -           | last_word
//
// An absorb beat is taken while idle; the beat that fills a 64-byte block
// then starts 64 rounds on the single round unit and a hash update.
// A finish pushes the marker, then the later padding bytes (8 to 71), runs
// one or two compressions, then gives eight output beats.
// Input is held off while padding, compressing or emitting the digest.
// Reset loads the initial hash values and clears the byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic             out_tlast
);
  import shs_pkg::*;

  shs_cmd_t  cmd;
  shs_stat_t status;

  // Sequencer
  shs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Hash datapath
  shs_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .status      (status),
    .digest_word (out_tdata)
  );

  assign out_tlast = status.emit_last;

`include "sha256_stream_hasher_top_assert.svh"

  // No input beat taken while the digest is on offer
  `SHS_ASSERT_NOW(a_no_in_during_emit, out_tvalid, !in_tready,
    "input ready during digest output")
  // Rounds never overlap input acceptance
  `SHS_ASSERT_NOW(a_no_in_during_round, cmd.round_en, !in_tready,
    "input ready during rounds")
  // A filled block starts compression on the next cycle
  `SHS_ASSERT_NEXT(a_fill_starts_round, cmd.push && status.blk_end, cmd.round_en,
    "block filled without compression")
  // The last digest beat ends the output burst
  `SHS_ASSERT_NEXT(a_last_ends_burst, out_tvalid && out_tready && out_tlast,
    !out_tvalid, "digest output ran past last word")

endmodule

`default_nettype wire

// File: test/sha256_stream_hasher_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_test
// Self-checking bench for the byte-stream SHA-256 hasher. Byte and finish
// beats are driven with random gaps while the digest side is stalled at
// random. A scoreboard computes each digest on its own and checks every
// output beat, word and last flag, in order.
// ----------------------------------------------------------------------------

module sha256_stream_hasher_top_test;
  import shs_pkg::*;

  localparam int ITEM_GOAL = 470;
  localparam int CALM_TAIL = 70;

  // Round constants of the compression
  localparam logic [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Chaining value at the start of every message
  localparam logic [31:0] CHAIN_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  // Running hash of the byte stream and the digest beats still owed
  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [60:0]  byte_total;
    logic [7:0]   block [64];
    digest_beat_t pending [$];
    int faults;
    int words_checked;
    int messages;
    int bytes_absorbed;

    function new();
      faults = 0;
      words_checked = 0;
      messages = 0;
      bytes_absorbed = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = CHAIN_IV[i];
      byte_total = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the current block and fold into the chain
    function void compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + RND_K[t] + w[t];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Absorb a byte, or pad the message and queue its eight digest words
    function void note_input(logic op, logic [7:0] data);
      logic [63:0]  bit_len;
      digest_beat_t beat;
      int pos;
      pos = int'(byte_total[5:0]);
      if (op == OP_ABSORB) begin
        block[pos] = data;
        byte_total = byte_total + 1'b1;
        bytes_absorbed++;
        if (pos == 63) compress();
        return;
      end
      bit_len = {byte_total, 3'b000};
      block[pos] = PAD_BYTE;
      pos++;
      // no room for the length: close this block and open another
      if (pos > 56) begin
        while (pos < 64) begin
          block[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) block[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        beat.word = chain[i];
        beat.last = (i == 7);
        pending.push_back(beat);
      end
      messages++;
      restart();
    endfunction

    task report_fault(string what);
      faults++;
      $display("ERROR digest beat %0d: %s", words_checked, what);
    endtask

    // Compare one output beat against the oldest owed word
    task check_result(logic [31:0] word, logic last);
      digest_beat_t want;
      if (pending.size() == 0) begin
        report_fault($sformatf("unexpected word %08h last %0b", word, last));
        return;
      end
      want = pending.pop_front();
      if (word !== want.word)
        report_fault($sformatf("word %08h, wanted %08h", word, want.word));
      if (last !== want.last)
        report_fault($sformatf("last %0b, wanted %0b", last, want.last));
      words_checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = OP_ABSORB;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  digest_scoreboard sb = new();
  int  sent_items = 0;
  logic calm = 1'b0;

  sha256_stream_hasher_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Drive one input beat, with an optional gap ahead of it
  task automatic push_beat(input logic op, input logic [7:0] data);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sent_items++;
    calm = (sent_items >= ITEM_GOAL - CALM_TAIL);
    sb.note_input(op, data);
  endtask

  // Stall the digest side in bursts, with calm stretches between
  initial begin
    repeat (4) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Check every accepted digest beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Main stimulus
  initial begin
    int boundary_lens [11];
    int len;
    int fill;
    boundary_lens = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 128};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty messages, with the ignored byte at both extremes
    push_beat(OP_FINISH, 8'h00);
    push_beat(OP_FINISH, 8'hFF);
    // short message with extreme bytes
    push_beat(OP_ABSORB, 8'h00);
    push_beat(OP_ABSORB, 8'hFF);
    push_beat(OP_ABSORB, 8'h61);
    push_beat(OP_ABSORB, 8'h62);
    push_beat(OP_ABSORB, 8'h63);
    push_beat(OP_FINISH, 8'h5A);
    // a single-byte message that looks like padding
    push_beat(OP_ABSORB, PAD_BYTE);
    push_beat(OP_FINISH, 8'hA5);

    // random messages, lengths biased towards block and padding boundaries
    while (sent_items < ITEM_GOAL) begin
      if ($urandom_range(0, 2) == 0)
        len = boundary_lens[$urandom_range(0, 10)];
      else
        len = $urandom_range(0, 70);
      // keep the run close to the item goal
      if (len > ITEM_GOAL - sent_items - 1)
        len = ITEM_GOAL - sent_items - 1;
      fill = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
        case (fill)
          0: push_beat(OP_ABSORB, 8'h00);
          1: push_beat(OP_ABSORB, 8'hFF);
          default: push_beat(OP_ABSORB, 8'($urandom));
        endcase
      end
      push_beat(OP_FINISH, 8'($urandom));
    end
    in_tvalid <= 1'b0;

    // drain the owed digest words, then watch for stray beats
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Hashed %0d messages from %0d bytes in %0d beats", sb.messages,
             sb.bytes_absorbed, sent_items);
    $display("Checked %0d digest words, %0d faults", sb.words_checked, sb.faults);
    if (sb.faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
